### rtl/fbpa_pkg.sv
`default_nettype none
// ============================================================================
// fbpa_pkg
// Shared types, codes and helpers of the fixed block pool allocator.
// ============================================================================
package fbpa_pkg;

    localparam int MAX_BLOCKS = 256;  // capacity of the link memory

    localparam int ADDR_W  = 32;  // byte addresses
    localparam int BYTES_W = 17;  // block_bytes register
    localparam int UNIT_W  = 18;  // block unit, 8..131072
    localparam int CNT_W   = 9;   // block counts and link values
    localparam int SPAN_W  = 27;  // count * unit
    localparam int QUO_W   = 9;   // quotient bits of the index divider
    localparam int STEP_W  = 4;   // divider step counter
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd2;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_INIT  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_BAD   = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT_SWEEP,
        S_ALLOC_READ,
        S_ALLOC_UPDATE,
        S_FREE_CHECK,
        S_FREE_DIVIDE,
        S_FREE_UPDATE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept_init;
        logic    accept_free;
        logic    sweep_write;
        logic    alloc_commit;
        logic    div_load;
        logic    div_step;
        logic    free_commit;
        logic    report;
        status_t report_status;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_done;
        logic pool_empty;
        logic out_of_range;
        logic div_last;
        logic free_bad;
        logic pool_full;
    } dp_stat_t;

    // Object size rounded up to a multiple of eight; zero counts as eight.
    function automatic logic [UNIT_W-1:0] unit_of(input logic [BYTES_W-1:0] bytes);
        logic [UNIT_W-1:0] b;
        b = (bytes == '0) ? UNIT_W'(8) : {1'b0, bytes};
        return (b + UNIT_W'(7)) & ~UNIT_W'(7);
    endfunction

endpackage
`default_nettype wire

### rtl/fbpa_ram.sv
`default_nettype none
// ============================================================================
// fbpa_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module fbpa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

### rtl/fbpa_ctrl.sv
`default_nettype none
// ============================================================================
// fbpa_ctrl
// Sequencer of the allocator: decodes a command and steps the datapath.
// ============================================================================
module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] mode,
    input  wire dp_stat_t   stat,
    output dp_cmd_t         cmd,
    output logic            busy,
    output logic            done
);

    state_t state_reg, state_next;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.report;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.report_status = STATUS_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (mode_t'(mode))
                        MODE_ALLOC: state_next = S_ALLOC_READ;
                        MODE_FREE:
                        begin
                            cmd.accept_free = 1'b1;
                            state_next      = S_FREE_CHECK;
                        end
                        MODE_INIT:
                        begin
                            cmd.accept_init = 1'b1;
                            state_next      = S_INIT_SWEEP;
                        end
                        MODE_NOP:   cmd.report = 1'b1;
                        default:    cmd.report = 1'b1;
                    endcase
                end
            end
            S_INIT_SWEEP:
            begin
                if (stat.sweep_done)
                begin
                    cmd.report = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.sweep_write = 1'b1;
                end
            end
            S_ALLOC_READ:
            begin
                if (stat.pool_empty)
                begin
                    cmd.report        = 1'b1;
                    cmd.report_status = STATUS_EMPTY;
                    state_next        = S_IDLE;
                end
                else
                begin
                    state_next = S_ALLOC_UPDATE;
                end
            end
            S_ALLOC_UPDATE:
            begin
                cmd.alloc_commit = 1'b1;
                cmd.report       = 1'b1;
                state_next       = S_IDLE;
            end
            S_FREE_CHECK:
            begin
                if (stat.out_of_range)
                begin
                    cmd.report        = 1'b1;
                    cmd.report_status = STATUS_BAD;
                    state_next        = S_IDLE;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    state_next   = S_FREE_DIVIDE;
                end
            end
            S_FREE_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_FREE_UPDATE;
                end
            end
            S_FREE_UPDATE:
            begin
                cmd.report = 1'b1;
                state_next = S_IDLE;
                if (stat.free_bad)
                begin
                    cmd.report_status = STATUS_BAD;
                end
                else if (stat.pool_full)
                begin
                    cmd.report_status = STATUS_FULL;
                end
                else
                begin
                    cmd.free_commit = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire

### rtl/fbpa_dp.sv
`default_nettype none
// ============================================================================
// fbpa_dp
// Datapath: configuration, pool geometry, free list, index divider, results.
// ============================================================================
module fbpa_dp
    import fbpa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data,
    input  wire logic [ADDR_W-1:0]    block_address,
    input  wire dp_cmd_t              cmd,
    output dp_stat_t                  stat,
    output logic [ADDR_W-1:0]         granted_address,
    output logic [1:0]                status,
    output logic [CNT_W-1:0]          blocks_free
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    // Configuration registers.
    logic [ADDR_W-1:0]  cfg_base_reg;
    logic [BYTES_W-1:0] cfg_bytes_reg;
    logic [CNT_W-1:0]   cfg_count_reg;

    // Pool geometry latched by init, and free list control.
    logic [ADDR_W-1:0]  pool_base_reg;
    logic [UNIT_W-1:0]  pool_unit_reg;
    logic [CNT_W-1:0]   pool_count_reg;
    logic [SPAN_W-1:0]  span_reg;
    logic [SPAN_W-1:0]  prod_reg;
    logic [CNT_W-1:0]   head_reg;
    logic [CNT_W-1:0]   free_count_reg;
    logic [CNT_W-1:0]   sweep_cnt_reg;

    // Free path.
    logic [ADDR_W-1:0]  addr_reg;
    logic [SPAN_W-1:0]  rem_reg;
    logic [SPAN_W-1:0]  divisor_reg;
    logic [QUO_W-1:0]   quot_reg;
    logic [STEP_W-1:0]  step_reg;

    // Result registers.
    logic [ADDR_W-1:0]  granted_reg;
    status_t            status_reg;

    logic [CNT_W-1:0]   init_count;
    logic [ADDR_W-1:0]  offset;
    logic               rem_ge;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [CNT_W-1:0]   ram_wdata;
    logic [CNT_W-1:0]   link_rdata;

    always_comb
    begin
        if (32'(cfg_count_reg) > 32'(MAX_BLOCKS))
        begin
            init_count = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            init_count = cfg_count_reg;
        end
    end

    assign offset = addr_reg - pool_base_reg;
    assign rem_ge = (rem_reg >= divisor_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_base_reg   <= '0;
            cfg_bytes_reg  <= BYTES_W'(8);
            cfg_count_reg  <= CNT_W'(256);
            pool_base_reg  <= '0;
            pool_unit_reg  <= UNIT_W'(8);
            pool_count_reg <= '0;
            head_reg       <= '0;
            free_count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BASE_ADDRESS: cfg_base_reg  <= cfg_data;
                    CFG_BLOCK_BYTES:  cfg_bytes_reg <= cfg_data[BYTES_W-1:0];
                    CFG_BLOCK_COUNT:  cfg_count_reg <= cfg_data[CNT_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.accept_init)
            begin
                pool_base_reg  <= cfg_base_reg;
                pool_unit_reg  <= unit_of(cfg_bytes_reg);
                pool_count_reg <= init_count;
                head_reg       <= '0;
                free_count_reg <= init_count;
            end
            if (cmd.alloc_commit)
            begin
                free_count_reg <= free_count_reg - CNT_W'(1);
                head_reg       <= (free_count_reg != CNT_W'(1)) ? link_rdata : '0;
            end
            if (cmd.free_commit)
            begin
                free_count_reg <= free_count_reg + CNT_W'(1);
                head_reg       <= CNT_W'(quot_reg);
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        span_reg <= SPAN_W'(pool_count_reg) * SPAN_W'(pool_unit_reg);
        prod_reg <= SPAN_W'(head_reg) * SPAN_W'(pool_unit_reg);
        if (cmd.accept_init)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (cmd.sweep_write)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + CNT_W'(1);
        end
        if (cmd.accept_free)
        begin
            addr_reg <= block_address;
        end
        if (cmd.div_load)
        begin
            rem_reg     <= SPAN_W'(offset);
            divisor_reg <= SPAN_W'(pool_unit_reg) << (QUO_W - 1);
            quot_reg    <= '0;
            step_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - divisor_reg;
            end
            quot_reg    <= {quot_reg[QUO_W-2:0], rem_ge};
            divisor_reg <= divisor_reg >> 1;
            step_reg    <= step_reg + STEP_W'(1);
        end
        if (cmd.report)
        begin
            granted_reg <= cmd.alloc_commit ? (pool_base_reg + ADDR_W'(prod_reg)) : '0;
            status_reg  <= cmd.report_status;
        end
    end

    always_comb
    begin
        ram_we    = cmd.sweep_write || cmd.free_commit;
        ram_waddr = IDX_W'(sweep_cnt_reg);
        ram_wdata = sweep_cnt_reg + CNT_W'(1);
        if (cmd.free_commit)
        begin
            ram_waddr = IDX_W'(quot_reg);
            ram_wdata = (free_count_reg != '0) ? head_reg : pool_count_reg;
        end
    end

    fbpa_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (IDX_W'(head_reg)),
        .rdata (link_rdata)
    );

    always_comb
    begin
        stat.sweep_done   = (sweep_cnt_reg == pool_count_reg);
        stat.pool_empty   = (free_count_reg == '0) || (32'(head_reg) >= 32'(MAX_BLOCKS));
        stat.out_of_range = (offset >= ADDR_W'(span_reg));
        stat.div_last     = (step_reg == STEP_W'(QUO_W - 1));
        stat.free_bad     = (rem_reg != '0) || (32'(quot_reg) >= 32'(MAX_BLOCKS));
        stat.pool_full    = (free_count_reg >= pool_count_reg);
    end

    assign granted_address = granted_reg;
    assign status          = status_reg;
    assign blocks_free     = free_count_reg;

endmodule
`default_nettype wire

### rtl/fixed_block_pool_allocator_core.sv
`default_nettype none
// ============================================================================
// fixed_block_pool_allocator_core
// Fixed-size block pool with a free list linked by block index.
// ============================================================================
//
//  Channel   Handshake            Payload
//  --------  -------------------  ------------------------------------------
//  command   start, busy          mode, block_address
//  result    done (strobe)        granted_address, status, blocks_free
//  config    cfg_valid, cfg_ready cfg_index, cfg_data
//
// A command transaction is taken when start is high and busy is low; its
// result is marked by done for exactly one cycle, in the next cycle for a
// no-operation. An alloc reads the head, then updates the list. A free
// checks the address range and reports right after the check when it is out
// of range; else a restoring divider resolves one index bit per cycle, then
// the list is updated. An init writes one link entry per cycle through the
// single write port of the link memory. Busy is high while a command is in
// progress and never for a no-operation. The result side cannot stall.
// Reset is asynchronous and active low; it clears the controller, the free
// count and head, and the configuration and pool geometry registers, while
// the link memory is left unwritten until the first init.
//
// The configuration port is always ready. Its registers are read only when
// an init command is taken, which latches the pool geometry. A free first
// checks the address range against count * unit, then divides the offset by
// the unit; a nonzero remainder reports a bad address, and a free into a full
// pool reports full. An alloc pops the head and grants base + index * unit.

module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           mode,
    input  wire logic [ADDR_W-1:0]    block_address,

    output logic                      done,
    output logic [ADDR_W-1:0]         granted_address,
    output logic [1:0]                status,
    output logic [CNT_W-1:0]          blocks_free,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Configuration must be written only while the pool is quiet; the block itself does not enforce this.
    assign cfg_ready = 1'b1;

    fbpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    fbpa_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .block_address   (block_address),
        .cmd             (cmd),
        .stat            (stat),
        .granted_address (granted_address),
        .status          (status),
        .blocks_free     (blocks_free)
    );

endmodule
`default_nettype wire

### rtl/fbpa_checker.sv
`default_nettype none
// ============================================================================
// fbpa_checker
// Port-level assertions on the command and result channels of the allocator.
// ============================================================================
module fbpa_checker
    import fbpa_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic [1:0]        mode,
    input wire logic              done,
    input wire logic [ADDR_W-1:0] granted_address,
    input wire logic [1:0]        status,
    input wire logic [CNT_W-1:0]  blocks_free
);

    // A result only follows an accepted command or work in progress.
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result strobe without a command in flight");

    // Only a successful alloc grants an address.
    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> (granted_address == '0))
        else $error("address granted on a failed command");

    // An empty report means no block is free.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_EMPTY) |-> (blocks_free == '0))
        else $error("pool reported empty with free blocks");

    // The free count never exceeds the pool capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(blocks_free) <= 32'(MAX_BLOCKS))
        else $error("free count above capacity");

    // A no-operation answers in the next cycle.
    a_nop_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_NOP) |=> (done && status == STATUS_OK))
        else $error("no-operation result missing");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .mode            (mode),
    .done            (done),
    .granted_address (granted_address),
    .status          (status),
    .blocks_free     (blocks_free)
);
`default_nettype wire
